FILE: hdl/wgbs_pkg.sv
// shared types and constants for the wrapped grid bilinear sampler
// used by every module of the block but wgbs_ram; depends on nothing
`default_nettype none
package wgbs_pkg;

  localparam int unsigned MAX_SIDE   = 16;
  localparam int unsigned SIDE_W     = $clog2(MAX_SIDE);
  localparam int unsigned ADDR_W     = 2 * SIDE_W;
  localparam int unsigned DEPTH      = MAX_SIDE * MAX_SIDE;
  localparam int unsigned CELL_W     = 16;
  localparam int unsigned CFG_SIDE_W = 5;
  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned PDATA_W    = 32;
  localparam logic [CELL_W-1:0] ONE_Q15 = 16'h8000;

  typedef enum logic [1:0] {
    REG_WIDTH   = 2'd0,
    REG_HEIGHT  = 2'd1,
    REG_DEPOSIT = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_DEPOSIT = 2'd2,
    ACT_SAMPLE  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_CLEAR,
    CMD_PREP,
    CMD_WRITE,
    CMD_DEP_RD,
    CMD_DEP_WR,
    CMD_S0,
    CMD_S1,
    CMD_S2,
    CMD_S3,
    CMD_S4,
    CMD_S5,
    CMD_S6,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    logic [CFG_SIDE_W-1:0] width_cells;
    logic [CFG_SIDE_W-1:0] height_cells;
    logic [CELL_W-1:0]     deposit_amount;
  } cfg_t;

  typedef struct packed {
    action_e action;
    logic    out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: hdl/wgbs_ram.sv
// generic single write port, single read port ram with registered read
// no package dependency
`default_nettype none
module wgbs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hdl/wgbs_cfg.sv
// apb configuration registers: grid width, grid height, deposit amount
// depends on wgbs_pkg
`default_nettype none
module wgbs_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [wgbs_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [wgbs_pkg::PDATA_W-1:0]   pwdata,
  output logic      [wgbs_pkg::PDATA_W-1:0]   prdata,
  output logic                                pready,
  output wgbs_pkg::cfg_t                      cfg_o
);

  wgbs_pkg::cfg_t cfg_q, cfg_d;
  wgbs_pkg::reg_e idx;
  logic           wr_en;

  assign idx    = wgbs_pkg::reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        wgbs_pkg::REG_WIDTH:   cfg_d.width_cells    = pwdata[wgbs_pkg::CFG_SIDE_W-1:0];
        wgbs_pkg::REG_HEIGHT:  cfg_d.height_cells   = pwdata[wgbs_pkg::CFG_SIDE_W-1:0];
        wgbs_pkg::REG_DEPOSIT: cfg_d.deposit_amount = pwdata[wgbs_pkg::CELL_W-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      wgbs_pkg::REG_WIDTH:   prdata = wgbs_pkg::PDATA_W'(cfg_q.width_cells);
      wgbs_pkg::REG_HEIGHT:  prdata = wgbs_pkg::PDATA_W'(cfg_q.height_cells);
      wgbs_pkg::REG_DEPOSIT: prdata = wgbs_pkg::PDATA_W'(cfg_q.deposit_amount);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_cells    <= 5'd5;
      cfg_q.height_cells   <= 5'd5;
      cfg_q.deposit_amount <= 16'd4096;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: hdl/wgbs_ctrl.sv
// controller state machine: sequences load, update and sample steps
// depends on wgbs_pkg; drives the datapath through commands only
`default_nettype none
module wgbs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wgbs_pkg::status_t      status_i,
  output wgbs_pkg::cmd_e         cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_WRITE,
    ST_DEP_RD,
    ST_DEP_WR,
    ST_S0,
    ST_S1,
    ST_S2,
    ST_S3,
    ST_S4,
    ST_S5,
    ST_S6,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = wgbs_pkg::CMD_NOP;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = wgbs_pkg::CMD_LOAD;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        case (status_i.action)
          wgbs_pkg::ACT_CLEAR: begin
            cmd_o   = wgbs_pkg::CMD_CLEAR;
            state_d = ST_IDLE;
          end
          wgbs_pkg::ACT_WRITE: begin
            cmd_o   = wgbs_pkg::CMD_PREP;
            state_d = ST_WRITE;
          end
          wgbs_pkg::ACT_DEPOSIT: begin
            cmd_o   = wgbs_pkg::CMD_PREP;
            state_d = ST_DEP_RD;
          end
          default: begin
            cmd_o   = wgbs_pkg::CMD_PREP;
            state_d = ST_S0;
          end
        endcase
      end
      ST_WRITE: begin
        cmd_o   = wgbs_pkg::CMD_WRITE;
        state_d = ST_IDLE;
      end
      ST_DEP_RD: begin
        cmd_o   = wgbs_pkg::CMD_DEP_RD;
        state_d = ST_DEP_WR;
      end
      ST_DEP_WR: begin
        cmd_o   = wgbs_pkg::CMD_DEP_WR;
        state_d = ST_IDLE;
      end
      ST_S0: begin
        cmd_o   = wgbs_pkg::CMD_S0;
        state_d = ST_S1;
      end
      ST_S1: begin
        cmd_o   = wgbs_pkg::CMD_S1;
        state_d = ST_S2;
      end
      ST_S2: begin
        cmd_o   = wgbs_pkg::CMD_S2;
        state_d = ST_S3;
      end
      ST_S3: begin
        cmd_o   = wgbs_pkg::CMD_S3;
        state_d = ST_S4;
      end
      ST_S4: begin
        cmd_o   = wgbs_pkg::CMD_S4;
        state_d = ST_S5;
      end
      ST_S5: begin
        cmd_o   = wgbs_pkg::CMD_S5;
        state_d = ST_S6;
      end
      ST_S6: begin
        cmd_o   = wgbs_pkg::CMD_S6;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o   = wgbs_pkg::CMD_EMIT;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule
`default_nettype wire

FILE: hdl/wgbs_dpath.sv
// datapath: item registers, index wrap, grid store with valid bits,
// shared multiply-accumulate and output register; depends on wgbs_pkg, wgbs_ram
`default_nettype none
module wgbs_dpath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wgbs_pkg::cmd_e                      cmd_i,
  input  wgbs_pkg::cfg_t                      cfg_i,
  input  wire logic [1:0]                     action_i,
  input  wire logic [3:0]                     cell_x_i,
  input  wire logic [3:0]                     cell_y_i,
  input  wire logic [15:0]                    cell_value_i,
  input  wire logic [15:0]                    coord_x_i,
  input  wire logic [15:0]                    coord_y_i,
  input  wire logic                           out_ready_i,
  output logic                                out_valid_o,
  output logic      [15:0]                    sample_value_o,
  output wgbs_pkg::status_t                   status_o
);

  localparam int unsigned SW = wgbs_pkg::SIDE_W;
  localparam int unsigned AW = wgbs_pkg::ADDR_W;
  localparam int unsigned CW = wgbs_pkg::CELL_W;
  localparam int unsigned FW = wgbs_pkg::CFG_SIDE_W;

  function automatic logic [FW-1:0] side_of(logic [FW-1:0] reg_val);
    logic [FW-1:0] s;
    if (reg_val == '0) begin
      s = FW'(1);
    end else if (reg_val > FW'(wgbs_pkg::MAX_SIDE)) begin
      s = FW'(wgbs_pkg::MAX_SIDE);
    end else begin
      s = reg_val;
    end
    return s;
  endfunction

  // restoring remainder, one quotient bit per step
  function automatic logic [SW-1:0] wrap_idx(logic [3:0] idx, logic [FW-1:0] side);
    logic [8:0] r;
    logic [8:0] t;
    r = 9'(idx);
    for (int i = 3; i >= 0; i--) begin
      t = 9'(side) << i;
      if (r >= t) begin
        r = r - t;
      end
    end
    return r[SW-1:0];
  endfunction

  wgbs_pkg::action_e action_q;
  logic [3:0]        cx_q, cy_q;
  logic [CW-1:0]     val_q, px_q, py_q;
  logic [SW-1:0]     x1_q, x2_q, y1_q, y2_q;
  logic [15:0]       fx_q, fy_q;
  logic [16:0]       gx_q, gy_q;
  logic [AW-1:0]     slot_q;
  logic [31:0]       acc_x_q;
  logic [48:0]       acc_q;
  logic [CW-1:0]     hold_q;
  logic [CW-1:0]     out_q;
  logic              out_valid_q, out_valid_d;
  logic [wgbs_pkg::DEPTH-1:0] valid_q;
  logic              rd_valid_q;

  logic [FW-1:0]     w, h;
  logic [20:0]       sx, sy;
  logic [SW-1:0]     x1, y1, x2, y2;
  logic [FW-1:0]     x1p, y1p;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CW-1:0]     ram_wdata, ram_rdata, cell_rd;
  logic [16:0]       dep_sum;

  logic [31:0]       mul_a;
  logic [16:0]       mul_b;
  logic [48:0]       prod;
  logic [48:0]       rnd;
  logic [16:0]       res;

  assign w = side_of(cfg_i.width_cells);
  assign h = side_of(cfg_i.height_cells);

  assign sx  = 21'(px_q) * 21'(w);
  assign sy  = 21'(py_q) * 21'(h);
  assign x1  = sx[16 +: SW];
  assign y1  = sy[16 +: SW];
  assign x1p = FW'(x1) + FW'(1);
  assign y1p = FW'(y1) + FW'(1);
  assign x2  = (x1p == w) ? '0 : x1p[SW-1:0];
  assign y2  = (y1p == h) ? '0 : y1p[SW-1:0];

  assign cell_rd = rd_valid_q ? ram_rdata : '0;
  assign dep_sum = 17'(cell_rd) + 17'(cfg_i.deposit_amount);

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = slot_q;
    ram_wdata = (val_q > wgbs_pkg::ONE_Q15) ? wgbs_pkg::ONE_Q15 : val_q;
    case (cmd_i)
      wgbs_pkg::CMD_WRITE: begin
        ram_we = 1'b1;
      end
      wgbs_pkg::CMD_DEP_RD: begin
        ram_re = 1'b1;
      end
      wgbs_pkg::CMD_DEP_WR: begin
        ram_we    = 1'b1;
        ram_wdata = (dep_sum > 17'(wgbs_pkg::ONE_Q15)) ? wgbs_pkg::ONE_Q15 : dep_sum[CW-1:0];
      end
      wgbs_pkg::CMD_S0: begin
        ram_re    = 1'b1;
        ram_raddr = {x1_q, y1_q};
      end
      wgbs_pkg::CMD_S1: begin
        ram_re    = 1'b1;
        ram_raddr = {x2_q, y1_q};
      end
      wgbs_pkg::CMD_S2: begin
        ram_re    = 1'b1;
        ram_raddr = {x1_q, y2_q};
      end
      wgbs_pkg::CMD_S3: begin
        ram_re    = 1'b1;
        ram_raddr = {x2_q, y2_q};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // x blend first, then y blend of the two row results
  always_comb begin
    mul_a = 32'(cell_rd);
    mul_b = gx_q;
    case (cmd_i)
      wgbs_pkg::CMD_S2: mul_b = 17'(fx_q);
      wgbs_pkg::CMD_S3: begin
        mul_a = acc_x_q;
        mul_b = gy_q;
      end
      wgbs_pkg::CMD_S4: mul_a = 32'(hold_q);
      wgbs_pkg::CMD_S5: begin
        mul_a = 32'(hold_q);
        mul_b = 17'(fx_q);
      end
      wgbs_pkg::CMD_S6: begin
        mul_a = acc_x_q;
        mul_b = 17'(fy_q);
      end
      default: mul_b = gx_q;
    endcase
  end

  assign prod = 49'(mul_a) * 49'(mul_b);
  assign rnd  = acc_q + (49'(1) << 31);
  assign res  = rnd[48:32];

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      wgbs_pkg::CMD_LOAD: begin
        action_q <= wgbs_pkg::action_e'(action_i);
        cx_q     <= cell_x_i;
        cy_q     <= cell_y_i;
        val_q    <= cell_value_i;
        px_q     <= coord_x_i;
        py_q     <= coord_y_i;
      end
      wgbs_pkg::CMD_PREP: begin
        x1_q   <= x1;
        x2_q   <= x2;
        y1_q   <= y1;
        y2_q   <= y2;
        fx_q   <= sx[15:0];
        fy_q   <= sy[15:0];
        gx_q   <= 17'h10000 - 17'(sx[15:0]);
        gy_q   <= 17'h10000 - 17'(sy[15:0]);
        slot_q <= {wrap_idx(cx_q, w), wrap_idx(cy_q, h)};
      end
      wgbs_pkg::CMD_S1: acc_x_q <= prod[31:0];
      wgbs_pkg::CMD_S2: acc_x_q <= acc_x_q + prod[31:0];
      wgbs_pkg::CMD_S3: begin
        acc_q  <= prod;
        hold_q <= cell_rd;
      end
      wgbs_pkg::CMD_S4: begin
        acc_x_q <= prod[31:0];
        hold_q  <= cell_rd;
      end
      wgbs_pkg::CMD_S5: acc_x_q <= acc_x_q + prod[31:0];
      wgbs_pkg::CMD_S6: acc_q   <= acc_q + prod;
      wgbs_pkg::CMD_EMIT: begin
        out_q <= (res > 17'(wgbs_pkg::ONE_Q15)) ? wgbs_pkg::ONE_Q15 : res[CW-1:0];
      end
      default: begin
        out_q <= out_q;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i == wgbs_pkg::CMD_EMIT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i == wgbs_pkg::CMD_CLEAR) begin
        valid_q <= '0;
      end else if (ram_we) begin
        valid_q[slot_q] <= 1'b1;
      end
      if (ram_re) begin
        rd_valid_q <= valid_q[ram_raddr];
      end
    end
  end

  wgbs_ram #(
    .WIDTH (CW),
    .DEPTH (wgbs_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o       = out_valid_q;
  assign sample_value_o    = out_q;
  assign status_o.action   = action_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule
`default_nettype wire

FILE: hdl/wrapped_grid_bilinear_sampler.sv
// top level of the toroidal grid bilinear sampler
// depends on wgbs_pkg, wgbs_cfg, wgbs_ctrl, wgbs_dpath
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------------
//   input    | in_valid_i / in_ready_o| action, cell_x/y, cell_value, coord_x/y
//   output   | out_valid_o/out_ready_i| sample_value
//   config   | psel, penable, pwrite  | paddr, pwdata, prdata (pready tied high)
//
// inputs are taken only in idle, so a new transfer waits until the previous one is done;
// a sample makes four reads through the one read port of the grid ram, which feed one
// shared 32x17 multiply-accumulate, then rounding into the output register
// reset clears the grid at once through per-cell valid bits; clear does the same
// a sample waits in its last step while the previous result is not taken
`default_nettype none
module wrapped_grid_bilinear_sampler (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     action_i,
  input  wire logic [3:0]                     cell_x_i,
  input  wire logic [3:0]                     cell_y_i,
  input  wire logic [15:0]                    cell_value_i,
  input  wire logic [15:0]                    coord_x_i,
  input  wire logic [15:0]                    coord_y_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [15:0]                    sample_value_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [wgbs_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [wgbs_pkg::PDATA_W-1:0]   pwdata,
  output logic      [wgbs_pkg::PDATA_W-1:0]   prdata,
  output logic                                pready
);

  wgbs_pkg::cfg_t    cfg;
  wgbs_pkg::cmd_e    cmd;
  wgbs_pkg::status_t status;

  wgbs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wgbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wgbs_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_i          (cfg),
    .action_i       (action_i),
    .cell_x_i       (cell_x_i),
    .cell_y_i       (cell_y_i),
    .cell_value_i   (cell_value_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .sample_value_o (sample_value_o),
    .status_o       (status)
  );

endmodule
`default_nettype wire
